// ----- rtl/elf_string_hash_mod_assert.svh -----
// Assertion macros for the port-level checker file.
`ifndef ELF_STRING_HASH_MOD_ASSERT_SVH
`define ELF_STRING_HASH_MOD_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ELF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("elf hash assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ELF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("elf hash assertion failed");

`endif

// ----- rtl/elf_hash_pkg.sv -----
// Package: widths, constants, types and the hash step for the ELF string hash block.
package elf_hash_pkg;

	localparam int unsigned HashW  = 32;
	localparam int unsigned ModW   = 31;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CntW   = $clog2(HashW + 1);

	localparam logic [ModW-1:0]  ModReset  = ModW'(1024);
	localparam logic [HashW-1:0] TopNibble = 32'hF000_0000;
	localparam int unsigned      FoldShift = 24;
	localparam int unsigned      StepShift = 4;
	localparam logic [HashW-1:0] ByteBias  = 32'h0000_0020;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic            done;
		logic [ModW-1:0] rem;
	} div_stat_t;

	function automatic logic [HashW-1:0] hash_step(
		input logic [HashW-1:0] h,
		input logic [ByteW-1:0] b
	);
		logic [HashW-1:0] sum;
		logic [HashW-1:0] top;
		logic [HashW-1:0] sext;
		sext = {{(HashW - ByteW){b[ByteW-1]}}, b};
		sum  = (h << StepShift) + sext - ByteBias;
		top  = sum & TopNibble;
		return (sum ^ (top >> FoldShift)) & ~top;
	endfunction

endpackage

// ----- rtl/elf_hash_div.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module elf_hash_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [elf_hash_pkg::HashW-1:0]       dividend,
	input  logic [elf_hash_pkg::ModW-1:0]        divisor,
	output elf_hash_pkg::div_stat_t              stat
);

	logic                            busy_q;
	logic                            done_q;
	logic [elf_hash_pkg::CntW-1:0]   cnt_q;
	logic [elf_hash_pkg::HashW-1:0]  dvd_q;
	logic [elf_hash_pkg::ModW-1:0]   dsr_q;
	logic [elf_hash_pkg::ModW-1:0]   rem_q;
	logic [elf_hash_pkg::ModW:0]     trial;
	logic [elf_hash_pkg::ModW:0]     diff;
	logic [elf_hash_pkg::ModW-1:0]   rem_nxt;

	assign trial   = {rem_q, dvd_q[elf_hash_pkg::HashW-1]};
	assign diff    = trial - {1'b0, dsr_q};
	assign rem_nxt = (trial >= {1'b0, dsr_q}) ? diff[elf_hash_pkg::ModW-1:0]
		: trial[elf_hash_pkg::ModW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= elf_hash_pkg::CntW'(elf_hash_pkg::HashW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - elf_hash_pkg::CntW'(1);
				if (cnt_q == elf_hash_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
	end

	// zero modulus reads as zero
	assign stat.done = done_q;
	assign stat.rem  = (dsr_q == '0) ? '0 : rem_q;

endmodule

// ----- rtl/elf_string_hash_mod.sv -----
// Top level: streaming ELF-style string hash reduced modulo a bucket count.
// A byte that is not the last of its string is taken without a stall, and
// bytes may follow back to back. The last byte starts a bit-serial remainder
// unit that takes one dividend bit per cycle, so input stalls after it for
// the 32 remainder steps plus the handoff into the output register, longer
// if the previous bucket_index is still waiting to be taken. The output
// register lets the next string's bytes flow while a result waits.
// The modulus register mod_q resets to 1024; a modulus of 0 gives bucket_index 0.
module elf_string_hash_mod (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [elf_hash_pkg::ModW-1:0]       cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [elf_hash_pkg::ByteW-1:0]      char_byte,
	input  logic                                last_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [elf_hash_pkg::ModW-1:0]       bucket_index
);

	elf_hash_pkg::st_t               st_q;
	elf_hash_pkg::st_t               st_nxt;
	elf_hash_pkg::div_stat_t         div_stat;
	logic [elf_hash_pkg::ModW-1:0]   mod_q;
	logic [elf_hash_pkg::HashW-1:0]  hash_q;
	logic [elf_hash_pkg::HashW-1:0]  hash_nxt;
	logic [elf_hash_pkg::ModW-1:0]   bucket_q;
	logic                            out_valid_q;
	logic                            in_acc;
	logic                            div_start;
	logic                            out_free;
	logic                            out_load;

	assign hash_nxt = elf_hash_pkg::hash_step(hash_q, char_byte);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			elf_hash_pkg::ST_IDLE: begin
				if (in_acc && last_byte)
					st_nxt = elf_hash_pkg::ST_DIV;
			end
			elf_hash_pkg::ST_DIV: begin
				if (div_stat.done)
					st_nxt = out_free ? elf_hash_pkg::ST_IDLE : elf_hash_pkg::ST_DONE;
			end
			elf_hash_pkg::ST_DONE: begin
				if (out_free)
					st_nxt = elf_hash_pkg::ST_IDLE;
			end
			default: st_nxt = elf_hash_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (st_q)
			elf_hash_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				div_start = in_valid && last_byte;
			end
			elf_hash_pkg::ST_DIV:  out_load = div_stat.done && out_free;
			elf_hash_pkg::ST_DONE: out_load = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= elf_hash_pkg::ST_IDLE;
			mod_q       <= elf_hash_pkg::ModReset;
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cfg_we)
				mod_q <= cfg_wdata;
			if (in_acc)
				hash_q <= last_byte ? '0 : hash_nxt;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			bucket_q <= div_stat.rem;
	end

	elf_hash_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (hash_nxt),
		.divisor  (mod_q),
		.stat     (div_stat)
	);

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

endmodule

// ----- rtl/elf_hash_chk.sv -----
// Port-level checker for the ELF string hash block, bound to the top level.
`include "elf_string_hash_mod_assert.svh"

module elf_hash_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              last_byte,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [elf_hash_pkg::ModW-1:0]     bucket_index
);

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// stalled request holds
	`ELF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bucket_index))
	// mid-string byte never stalls the next one
	`ELF_ASSERT_NEXT(a_mid_no_stall, in_acc && !last_byte, !in_stall)
	// last byte stalls the input after it
	`ELF_ASSERT_NEXT(a_last_stalls, in_acc && last_byte, in_stall)
	// a new request only appears while input is held off
	`ELF_ASSERT_NOW(a_out_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind elf_string_hash_mod elf_hash_chk u_chk (.*);
